[rtl/core/usage_packet_validate_accumulate_macros.svh]
// Assertion macros shared by the usage report checker.
`ifndef USAGE_PACKET_VALIDATE_ACCUMULATE_MACROS_SVH
`define USAGE_PACKET_VALIDATE_ACCUMULATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UPVA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upva assertion failed");

// Next-cycle implication, checked outside reset.
`define UPVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upva assertion failed");

`endif

[rtl/core/upva_pkg.sv]
// ----------------------------------------------------------------------------
// upva_pkg
// Types, constants and the CRC step shared by the usage report checker.
// ----------------------------------------------------------------------------
`default_nettype none

package upva_pkg;

    localparam int PACKET_BYTES    = 48;
    localparam int CRC_SPAN        = 44;
    localparam int PKT_BITS        = PACKET_BYTES * 8;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] MIN_STAMP  = 32'd1577836800;
    localparam logic [31:0] MAX_SKEW   = 32'd180;
    localparam logic signed [31:0] MAX_OFFSET = 32'sd50400;
    localparam logic [15:0] MAX_USED   = 16'd10000;
    localparam logic [10:0] TOKENS_PER_FOOD = 11'd1000;
    localparam logic [16:0] OFFSET_RESET = 17'd32400;
    localparam int AMT_BITS        = 54;
    // Inverse of 125 modulo 2^32, used for the exact division by 1000.
    localparam logic [31:0] INV_125 = 32'd652835029;
    // Token growth at or above 1000 * 2^32 always saturates a food counter.
    localparam logic [AMT_BITS-1:0] SAT_AMOUNT = 54'd4294967296000;
    localparam int FOOD_SLOTS_DEF  = 4;

    // Report status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HDR = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_STALE   = 2'd3;

    // Configuration register addresses.
    localparam logic [2:0] ADDR_SLOT = 3'd0;

    // One assembled report as handed from the front to the back.
    typedef struct packed {
        logic        hdr_ok;
        logic        prov;
        logic [2:0]  flags;
        logic [31:0] seq_no;
        logic [31:0] stream;
        logic [31:0] stamp;
        logic [63:0] tokens;
        logic [31:0] w0_reset;
        logic [15:0] w0_used;
        logic [15:0] w1_used;
        logic [31:0] w1_reset;
        logic [31:0] offset;
        logic [31:0] sent;
    } t_report;

    // One result word.
    typedef struct packed {
        logic [31:0] w1_reset;
        logic [31:0] w0_reset;
        logic [14:0] w1_used;
        logic [14:0] w0_used;
        logic [16:0] zone_offset;
        logic [31:0] food_total;
        logic        provider;
        logic [1:0]  status;
    } t_result;

    // Reflected CRC-32 over one byte, eight bit steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/upva_front.sv]
// ----------------------------------------------------------------------------
// upva_front
// Assembles report bytes in a shift line, runs the CRC and pushes each
// complete report with its header verdict into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module upva_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_start,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output upva_pkg::t_report      o_rpt
);
    import upva_pkg::*;

    logic [5:0]          r_cnt;
    logic [31:0]         r_crc;
    logic [PKT_BITS-9:0] r_shift;
    logic [5:0]          cnt_eff;
    logic [31:0]         crc_base;
    logic [31:0]         crc_next;
    logic                last_byte;
    logic                accept;
    logic [PKT_BITS-1:0] pkt;

    // A new word is taken whenever the queue has room.
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Byte position and CRC as seen by the current word.
    always_comb begin
        cnt_eff   = i_start ? 6'd0 : r_cnt;
        crc_base  = i_start ? 32'hFFFFFFFF : r_crc;
        crc_next  = (cnt_eff < 6'(CRC_SPAN)) ? crc_byte(crc_base, i_byte) : crc_base;
        last_byte = (cnt_eff == 6'(PACKET_BYTES - 1));
        pkt       = {i_byte, r_shift};
    end

    // Byte counter and running CRC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
            r_crc <= 32'hFFFFFFFF;
        end else if (accept) begin
            if (last_byte) begin
                r_cnt <= 6'd0;
                r_crc <= 32'hFFFFFFFF;
            end else begin
                r_cnt <= cnt_eff + 6'd1;
                r_crc <= crc_next;
            end
        end
    end

    // Shift line holding the earlier bytes of the report.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_shift <= {i_byte, r_shift[PKT_BITS-9:8]};
        end
    end

    // Field extraction from the full report.
    assign o_push = accept && last_byte;

    always_comb begin
        o_rpt.hdr_ok   = (pkt[7:0] == 8'd1) && (pkt[15:8] == 8'd1) &&
                         (pkt[23:17] == 7'd0) && (pkt[31:27] == 5'd0) &&
                         ((~crc_base) == pkt[383:352]);
        o_rpt.prov     = pkt[16];
        o_rpt.flags    = pkt[26:24];
        o_rpt.seq_no   = pkt[63:32];
        o_rpt.stream   = pkt[95:64];
        o_rpt.stamp    = pkt[127:96];
        o_rpt.tokens   = pkt[191:128];
        o_rpt.w0_reset = pkt[223:192];
        o_rpt.w0_used  = pkt[239:224];
        o_rpt.w1_used  = pkt[255:240];
        o_rpt.w1_reset = pkt[287:256];
        o_rpt.offset   = pkt[319:288];
        o_rpt.sent     = pkt[351:320];
    end

endmodule

`default_nettype wire

[rtl/core/upva_queue.sv]
// ----------------------------------------------------------------------------
// upva_queue
// Two-entry queue of assembled reports between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module upva_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  upva_pkg::t_report      i_rpt,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output upva_pkg::t_report      o_rpt
);
    import upva_pkg::*;

    t_report    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rpt   = r_mem[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rpt;
        end
    end

endmodule

`default_nettype wire

[rtl/core/upva_back.sv]
// ----------------------------------------------------------------------------
// upva_back
// Judges a queued report, updates the per-provider state and, when the token
// count grows, reduces the growth modulo 1000 by folding, finds the quotient by
// an exact multiply and credits the food slot.
// ----------------------------------------------------------------------------
`default_nettype none

`include "usage_packet_validate_accumulate_macros.svh"

module upva_back #(
    parameter int FOOD_SLOTS = upva_pkg::FOOD_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  upva_pkg::t_report      i_rpt,
    output logic                   o_pop,
    input  wire logic [1:0]        i_slot,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output upva_pkg::t_result      o_res
);
    import upva_pkg::*;

    localparam int SW = (FOOD_SLOTS > 1) ? $clog2(FOOD_SLOTS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_FOOD = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;

    logic [2:0]          r_state;
    logic [1:0]          r_status;
    logic [31:0]         r_stream [2];
    logic [31:0]         r_seq    [2];
    logic [31:0]         r_stamp  [2];
    logic [52:0]         r_tok    [2];
    logic [9:0]          r_rem    [2];
    logic [1:0]          r_hb;
    logic [14:0]         r_wused  [4];
    logic [31:0]         r_wreset [4];
    logic [31:0]         r_food   [FOOD_SLOTS];
    logic [16:0]         r_offset;
    logic [AMT_BITS-1:0] r_diff;
    logic [9:0]          r_remeff;
    logic [AMT_BITS-1:0] r_divn;
    logic [9:0]          r_dr;
    logic [31:0]         r_qlo;
    t_result             r_res;
    logic                r_ovalid;

    logic                p;
    logic [SW-1:0]       slot;
    logic                same;
    logic                hb_e;
    logic [52:0]         tc_e;
    logic [9:0]          rem_e;
    logic                tok_gt;
    logic                range_bad;
    logic                stale;
    logic [1:0]          status_c;
    logic [31:0]         skew;
    logic [AMT_BITS-1:0] fold_v;
    logic [AMT_BITS-1:0] exact_amt;
    logic [31:0]         q_lo;
    logic [32:0]         food_sum;
    logic                out_free;

    assign p        = i_rpt.prov;
    assign out_free = !r_ovalid || i_ready;

    // Selected slot, clamped to the slots that exist.
    always_comb begin
        if ({30'd0, i_slot} < 32'(FOOD_SLOTS)) begin
            slot = SW'(i_slot);
        end else begin
            slot = SW'(FOOD_SLOTS - 1);
        end
    end

    // Report judgment against the stored provider state.
    always_comb begin
        skew      = i_rpt.sent - i_rpt.stamp;
        same      = (r_stream[p] == i_rpt.stream);
        hb_e      = same && r_hb[p];
        tc_e      = same ? r_tok[p] : 53'd0;
        rem_e     = same ? r_rem[p] : 10'd0;
        tok_gt    = (i_rpt.tokens[52:0] > tc_e);
        range_bad = (i_rpt.stream == 32'd0) || (i_rpt.stamp < MIN_STAMP) ||
                    (i_rpt.sent < i_rpt.stamp) || (skew > MAX_SKEW) ||
                    ($signed(i_rpt.offset) < -MAX_OFFSET) ||
                    ($signed(i_rpt.offset) > MAX_OFFSET) ||
                    (i_rpt.tokens[63:53] != 11'd0) ||
                    (i_rpt.flags[1] && (i_rpt.w0_used > MAX_USED)) ||
                    (i_rpt.flags[2] && (i_rpt.w1_used > MAX_USED));
        stale     = same && (i_rpt.seq_no <= r_seq[p]);
        if (!i_rpt.hdr_ok) begin
            status_c = ST_BAD_HDR;
        end else if (range_bad) begin
            status_c = ST_RANGE;
        end else if (stale) begin
            status_c = ST_STALE;
        end else begin
            status_c = ST_OK;
        end
    end

    // Residue modulo 1000 by folding the bits above 2^10 back in as 24 each,
    // then the quotient of the exact multiple of 1000 through the inverse of 125.
    always_comb begin
        fold_v    = AMT_BITS'({r_divn[AMT_BITS-1:10], 4'd0}) +
                    AMT_BITS'({r_divn[AMT_BITS-1:10], 3'd0}) +
                    AMT_BITS'(r_divn[9:0]);
        exact_amt = r_diff - AMT_BITS'(r_dr);
        q_lo      = exact_amt[34:3] * INV_125;
        food_sum  = {1'b0, r_food[slot]} + {1'b0, r_qlo};
    end

    assign o_pop = (r_state == S_OUT) && out_free;

    // Sequencer and stored state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_hb     <= 2'b00;
            r_offset <= OFFSET_RESET;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_stream[i] <= 32'd0;
                r_seq[i]    <= 32'd0;
                r_stamp[i]  <= 32'd0;
                r_tok[i]    <= 53'd0;
                r_rem[i]    <= 10'd0;
            end
            for (int i = 0; i < 4; i++) begin
                r_wused[i]  <= 15'h7FFF;
                r_wreset[i] <= 32'd0;
            end
            for (int i = 0; i < FOOD_SLOTS; i++) begin
                r_food[i] <= 32'd0;
            end
        end else begin
            if (o_pop) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_status <= status_c;
                    r_state  <= S_OUT;
                    if (status_c == ST_OK) begin
                        r_stream[p] <= i_rpt.stream;
                        r_seq[p]    <= i_rpt.seq_no;
                        r_stamp[p]  <= i_rpt.stamp;
                        r_offset    <= i_rpt.offset[16:0];
                        if (!same) begin
                            r_rem[p] <= 10'd0;
                        end
                        if (i_rpt.flags[0]) begin
                            r_tok[p] <= (!hb_e || tok_gt) ? i_rpt.tokens[52:0] : tc_e;
                            r_hb[p]  <= 1'b1;
                            if (hb_e && tok_gt) begin
                                r_state <= S_ADD;
                            end
                        end else if (!same) begin
                            r_tok[p] <= 53'd0;
                            r_hb[p]  <= 1'b0;
                        end
                        r_wused[{p, 1'b0}]  <= i_rpt.flags[1] ? i_rpt.w0_used[14:0] : 15'h7FFF;
                        r_wused[{p, 1'b1}]  <= i_rpt.flags[2] ? i_rpt.w1_used[14:0] : 15'h7FFF;
                        r_wreset[{p, 1'b0}] <= (i_rpt.flags[1] && i_rpt.w0_reset > i_rpt.stamp)
                                               ? i_rpt.w0_reset : 32'd0;
                        r_wreset[{p, 1'b1}] <= (i_rpt.flags[2] && i_rpt.w1_reset > i_rpt.stamp)
                                               ? i_rpt.w1_reset : 32'd0;
                    end
                    r_diff   <= {1'b0, i_rpt.tokens[52:0]} - {1'b0, tc_e};
                    r_remeff <= rem_e;
                end
                S_ADD: begin
                    r_diff  <= r_diff + AMT_BITS'(r_remeff);
                    r_divn  <= r_diff + AMT_BITS'(r_remeff);
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    if (r_divn[AMT_BITS-1:10] == '0) begin
                        if ({1'b0, r_divn[9:0]} >= TOKENS_PER_FOOD) begin
                            r_dr <= 10'({1'b0, r_divn[9:0]} - TOKENS_PER_FOOD);
                        end else begin
                            r_dr <= r_divn[9:0];
                        end
                        r_state <= S_MUL;
                    end else begin
                        r_divn <= fold_v;
                    end
                end
                S_MUL: begin
                    r_qlo   <= q_lo;
                    r_state <= S_FOOD;
                end
                S_FOOD: begin
                    if ((r_diff >= SAT_AMOUNT) || food_sum[32]) begin
                        r_food[slot] <= 32'hFFFFFFFF;
                    end else begin
                        r_food[slot] <= food_sum[31:0];
                    end
                    r_rem[p] <= r_dr;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register, loaded from the stored state.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.status      <= r_status;
            r_res.provider    <= p;
            r_res.food_total  <= r_food[slot];
            r_res.zone_offset <= r_offset;
            r_res.w0_used     <= r_wused[{p, 1'b0}];
            r_res.w1_used     <= r_wused[{p, 1'b1}];
            r_res.w0_reset    <= r_wreset[{p, 1'b0}];
            r_res.w1_reset    <= r_wreset[{p, 1'b1}];
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    // The folding runs only while a report is in hand.
    `UPVA_ASSERT_NOW(a_fold_busy, i_clk, i_rst_n, r_state == S_FOLD, i_valid)
    // The residue stays below the divisor.
    `UPVA_ASSERT_NOW(a_rem_range, i_clk, i_rst_n, r_state == S_MUL, r_dr < 10'd1000)
    // A popped report leaves a result waiting.
    `UPVA_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, o_pop, o_valid && r_state == S_IDLE)

endmodule

`default_nettype wire

[rtl/core/usage_packet_validate_accumulate.sv]
// ----------------------------------------------------------------------------
// usage_packet_validate_accumulate
// Usage report checker: assembles 48-byte reports, validates them and
// credits token growth to a food counter.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s stream  in         tdata: data_byte; tuser: packet_start
// m stream  out        tdata: status, provider, food_total, zone offset,
//                      window0/1_used, window0/1_reset
// APB       in/out     register 0 at byte address 0: selected_slot
//
// One byte is taken per cycle, back to back, while the report queue has room.
// The result word follows the last byte of a report through the queue and
// the check; when food is credited, also through the add, the folding of the
// token growth to its residue modulo 1000, the multiply and the food update.
// A stalled result holds in the output register; bytes flow until the queue fills.
// Reset is synchronous, active low, and clears the control, provider and food state at once.
// ----------------------------------------------------------------------------
`default_nettype none

module usage_packet_validate_accumulate #(
    parameter int FOOD_SLOTS = upva_pkg::FOOD_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [7:0]    i_s_tdata,   // [7:0] data_byte
    input  wire logic          i_s_tuser,   // [0] packet_start
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // [1:0] status, [2] provider, [34:3] food_total, [51:35] zone offset,
    // [66:52] window0_used, [81:67] window1_used, [113:82] window0_reset,
    // [145:114] window1_reset, [151:146] zero
    output logic [151:0]       o_m_tdata,
    input  wire logic          i_psel,
    input  wire logic          i_penable,
    input  wire logic          i_pwrite,
    input  wire logic [2:0]    i_paddr,
    input  wire logic [31:0]   i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready
);
    import upva_pkg::*;

    logic    r_slot_lo;
    logic    r_slot_hi;
    logic    q_full;
    logic    q_valid;
    logic    push;
    logic    pop;
    t_report front_rpt;
    t_report q_rpt;
    t_result res;

    // Configuration register.
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == ADDR_SLOT) ? {30'd0, r_slot_hi, r_slot_lo} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_lo <= 1'b0;
            r_slot_hi <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && o_pready &&
                     (i_paddr == ADDR_SLOT)) begin
            r_slot_lo <= i_pwdata[0];
            r_slot_hi <= i_pwdata[1];
        end
    end

    upva_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_start  (i_s_tuser),
        .i_q_full (q_full),
        .o_push   (push),
        .o_rpt    (front_rpt)
    );

    upva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rpt   (front_rpt),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_rpt   (q_rpt)
    );

    upva_back #(
        .FOOD_SLOTS (FOOD_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_rpt   (q_rpt),
        .o_pop   (pop),
        .i_slot  ({r_slot_hi, r_slot_lo}),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    // Result word packed from the lowest field up.
    assign o_m_tdata = {6'd0, res};

endmodule

`default_nettype wire
